/* hdl/lap_pkg.sv */
// Package for the long-host-port argument parser.
// Holds the channel payload types, character classes and shared constants.
// No dependencies.
package lap_pkg;

    localparam int MaxFields = 512;
    localparam int AddrBytes = 16;
    localparam int IdxW      = $clog2(MaxFields + 1);
    localparam int AddrW     = $clog2(AddrBytes);
    localparam int SumW      = (IdxW + 1 > 10) ? IdxW + 1 : 10;
    localparam int QDepth    = 2;
    localparam int OutDepth  = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    localparam logic [7:0] FAM_IPV4 = 8'd4;
    localparam logic [7:0] FAM_IPV6 = 8'd6;

    localparam logic [1:0] ST_IPV4  = 2'd0;
    localparam logic [1:0] ST_IPV6  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_UNSUP = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } lap_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] addr_first_half;
        logic [63:0] addr_second_half;
        logic [15:0] port;
    } lap_out_t;

    typedef enum logic [2:0] {
        CL_ZERO,
        CL_SPACE,
        CL_DIGIT,
        CL_COMMA,
        CL_OTHER
    } lap_class_t;

    typedef struct packed {
        lap_class_t cls;
        logic [3:0] digit;
        logic       last;
    } lap_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lap_qstat_t;

endpackage

/* hdl/lap_front.sv */
// Front stage of the parser: takes request characters and classifies them.
// Depends on lap_pkg.
module lap_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lap_pkg::lap_in_t   in_data,
    output logic               item_valid,
    output lap_pkg::lap_item_t item,
    input  logic               item_ready
);
    import lap_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lap_item_t item_reg;
    lap_item_t item_next;
    logic      accept;

    function automatic lap_item_t classify(lap_in_t d);
        lap_item_t r;
        r.last  = d.last;
        r.digit = 4'(d.ch - CH_DIG0);
        if (d.ch == CH_NUL)
            r.cls = CL_ZERO;
        else if (d.ch == CH_SPACE || (d.ch >= CH_TAB && d.ch <= CH_CR))
            r.cls = CL_SPACE;
        else if (d.ch >= CH_DIG0 && d.ch <= CH_DIG9)
            r.cls = CL_DIGIT;
        else if (d.ch == CH_COMMA)
            r.cls = CL_COMMA;
        else
            r.cls = CL_OTHER;
        return r;
    endfunction

    assign full   = valid_reg && !item_ready;
    assign accept = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = classify(in_data);
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/lap_queue.sv */
// Short queue of classified characters between the front and back stages.
// Depends on lap_pkg.
module lap_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  lap_pkg::lap_item_t  wr_item,
    input  logic                rd_en,
    output lap_pkg::lap_item_t  rd_item,
    output lap_pkg::lap_qstat_t stat
);
    import lap_pkg::*;

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    lap_item_t       slot_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
        return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    assign rd_item    = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CntW'(QDepth));
    assign stat.empty = (count_reg == '0);

endmodule

/* hdl/lap_back.sv */
// Back stage of the parser: field scanner, consistency check and result queue.
// Depends on lap_pkg.
module lap_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  lap_pkg::lap_item_t  q_item,
    input  lap_pkg::lap_qstat_t q_stat,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output lap_pkg::lap_out_t   out_data
);
    import lap_pkg::*;

    localparam int OutCntW  = $clog2(OutDepth + 1);
    localparam int OutPtrW  = (OutDepth > 1) ? $clog2(OutDepth) : 1;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                        phase;
        logic [IdxW-1:0]               idx;
        logic [7:0]                    accum;
        logic [7:0]                    family;
        logic [7:0]                    alen;
        logic [7:0]                    plen;
        logic [AddrBytes-1:0][7:0]     addr;
        logic [15:0]                   port;
        logic                          err;
    } scan_t;

    scan_t              scan_reg;
    scan_t              scan_next;
    logic               ipv6_en_reg;
    lap_out_t           res_reg [OutDepth];
    logic [OutPtrW-1:0] wr_ptr_reg;
    logic [OutPtrW-1:0] rd_ptr_reg;
    logic [OutCntW-1:0] count_reg;
    logic [OutCntW-1:0] count_next;
    lap_out_t           res_new;
    logic               res_push;
    logic               res_pop;

    function automatic scan_t cleared();
        scan_t r;
        r        = '0;
        r.phase  = PH_SKIP;
        return r;
    endfunction

    function automatic logic [OutPtrW-1:0] advance(logic [OutPtrW-1:0] p);
        return (p == OutPtrW'(OutDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    // Stores the current field according to its position in the argument.
    function automatic scan_t close_field(scan_t s);
        scan_t           r;
        logic [IdxW-1:0] off;
        logic [SumW-1:0] k;
        logic [SumW-1:0] base;
        r    = s;
        off  = s.idx - IdxW'(2);
        k    = SumW'(s.idx);
        base = SumW'(s.alen) + SumW'(2);
        if (s.idx == IdxW'(0))
            r.family = s.accum;
        if (s.idx == IdxW'(1))
            r.alen = s.accum;
        if (k >= SumW'(2) && k < SumW'(2 + AddrBytes))
            r.addr[off[AddrW-1:0]] = s.accum;
        if (k >= SumW'(2))
        begin
            if (k == base)
                r.plen = s.accum;
            if (k == base + SumW'(1))
                r.port[15:8] = s.accum;
            if (k == base + SumW'(2))
                r.port[7:0] = s.accum;
        end
        r.accum = '0;
        return r;
    endfunction

    function automatic scan_t finish(scan_t s);
        scan_t r;
        r = s;
        if (s.phase != PH_DONE)
        begin
            r       = close_field(s);
            r.phase = PH_DONE;
        end
        return r;
    endfunction

    function automatic scan_t scan_char(scan_t s, lap_item_t it);
        scan_t       r;
        logic [11:0] prod;
        r    = s;
        prod = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0} + {8'h00, it.digit};
        unique case (it.cls)
            CL_ZERO, CL_SPACE:
                r = finish(s);
            CL_DIGIT:
                r.accum = prod[7:0];
            CL_COMMA:
            begin
                r     = close_field(s);
                r.idx = r.idx + 1'b1;
                // The field count limit closes an empty final field at once.
                if (r.idx >= IdxW'(MaxFields))
                    r = finish(r);
            end
            default:
            begin
                r.err   = 1'b1;
                r.phase = PH_DONE;
            end
        endcase
        return r;
    endfunction

    function automatic scan_t step(scan_t s, lap_item_t it);
        scan_t r;
        scan_t t;
        r       = s;
        t       = s;
        t.phase = PH_SCAN;
        unique case (s.phase)
            PH_SKIP:
            begin
                if (it.cls == CL_ZERO)
                    r = finish(s);
                else if (it.cls != CL_SPACE)
                    r = scan_char(t, it);
            end
            PH_SCAN:
                r = scan_char(s, it);
            default:
                r = s;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pack(scan_t s, int from, int count);
        logic [63:0] w;
        logic [7:0]  b;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = '0;
            if (i < count && from + i < AddrBytes)
                b = s.addr[AddrW'(from + i)];
            w = {w[55:0], b};
        end
        return w;
    endfunction

    function automatic lap_out_t make_result(scan_t s, logic v6_en);
        lap_out_t r;
        logic     ok;
        r  = '0;
        r.status = ST_ERROR;
        ok = !s.err &&
             (SumW'(s.idx) + SumW'(1) == SumW'(s.alen) + SumW'(s.plen) + SumW'(3));
        if (ok)
        begin
            if (s.family == FAM_IPV4)
            begin
                r.status          = ST_IPV4;
                r.addr_first_half = pack(s, 0, 4);
                r.port            = s.port;
            end
            else if (s.family == FAM_IPV6 && v6_en)
            begin
                r.status           = ST_IPV6;
                r.addr_first_half  = pack(s, 0, 8);
                r.addr_second_half = pack(s, 8, 8);
                r.port             = s.port;
            end
            else
            begin
                r.status = ST_UNSUP;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        scan_t stepped;
        scan_t done;
        stepped   = step(scan_reg, q_item);
        done      = finish(stepped);
        res_new   = make_result(done, ipv6_en_reg);
        q_pop     = !q_stat.empty && (!q_item.last || count_reg != OutCntW'(OutDepth));
        res_push  = q_pop && q_item.last;
        res_pop   = pop && !empty;
        scan_next = scan_reg;
        if (q_pop)
            scan_next = q_item.last ? cleared() : stepped;
        count_next = count_reg;
        if (res_push && !res_pop)
            count_next = count_reg + 1'b1;
        else if (res_pop && !res_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= cleared();
            ipv6_en_reg <= 1'b1;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            scan_reg  <= scan_next;
            count_reg <= count_next;
            if (cfg_valid)
                ipv6_en_reg <= cfg_data;
            if (res_push)
                wr_ptr_reg <= advance(wr_ptr_reg);
            if (res_pop)
                rd_ptr_reg <= advance(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_reg[wr_ptr_reg] <= res_new;
    end

    assign empty    = (count_reg == '0);
    assign out_data = res_reg[rd_ptr_reg];

endmodule

/* hdl/lprt_address_parser.sv */
// Top level of the long-host-port argument parser.
// Depends on lap_pkg, lap_front, lap_queue and lap_back.
//
// Characters of an argument are written one per request on the input queue
// port: a request is taken at a clock edge where push is high and full is low.
// The request marked last closes the argument and produces exactly one result
// request; all other characters produce none. A result stays on out_data while
// empty is low and leaves at an edge where pop is high.
// The path is front register, a two-entry character queue, then the scanner,
// which updates the field state once for each character, so one character
// is taken every cycle while full is low. A result is written into the result
// queue when the scanner takes its last character from the character queue.
// The result queue holds two results. When it is full the scanner stops on the
// next last character, the character queue and front register fill, and full
// rises; nothing is dropped.
// Reset empties all queues, clears the scan state and sets ipv6_enable. The
// configuration channel is always ready and should only be written while idle.
module lprt_address_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              push,
    output logic              full,
    input  lap_pkg::lap_in_t  in_data,
    output logic              empty,
    input  logic              pop,
    output lap_pkg::lap_out_t out_data
);
    import lap_pkg::*;

    logic       f_valid;
    lap_item_t  f_item;
    logic       q_push;
    logic       q_pop;
    lap_item_t  q_item;
    lap_qstat_t q_stat;

    assign cfg_ready = 1'b1;
    assign q_push    = f_valid && !q_stat.full;

    lap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_data    (in_data),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (!q_stat.full)
    );

    lap_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (f_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    lap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_item    (q_item),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

    // The scanner must never take from an empty character queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("scanner read from an empty character queue");

    // Back-pressure reaches the input only when the front register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> f_valid && q_stat.full)
        else $error("full raised without a blocked front register");

    // A character taken at the input is held in the front register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) push && !full |=> f_valid)
        else $error("accepted character lost in the front stage");

endmodule

/* bench/lprt_address_parser_test.sv */
// Self-checking testbench for lprt_address_parser: feeds long-host-port arguments
// one character per request; results are checked against a model or a table.
// Depends on lap_pkg and the lprt_address_parser RTL.
module lprt_address_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lap_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int HoldOff    = 400;
    localparam int DrainWait  = 20;
    localparam int IdleWait   = 8;

    // A tilde in the directed text stands for a zero character.
    localparam logic [7:0] NulMark = 8'h7E;

    localparam lap_out_t ErrorOut = '{ST_ERROR, 64'h0, 64'h0, 16'h0};
    localparam lap_out_t UnsupOut = '{ST_UNSUP, 64'h0, 64'h0, 16'h0};

    typedef enum logic [1:0] {SKIPPING, SCANNING, STOPPED} scan_phase_t;

    typedef struct {
        string    text;
        int       commas;
        string    tail;
        bit       known;
        lap_out_t want;
    } arg_row_t;

    arg_row_t directed_args [19] = '{
        '{"4,4,255,0,255,0,2,255,255", 0, "", 1'b1,
          '{ST_IPV4, 64'hFF00FF00_00000000, 64'h0, 16'hFFFF}},
        '{"6,16,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,2,0,21", 0, "", 1'b1,
          '{ST_IPV6, 64'h01020304_05060708, 64'h090A0B0C_0D0E0F10, 16'h0015}},
        '{"~", 0, "", 1'b1, ErrorOut},
        '{" \t\v4,4,10,0,0,1,2,1,0 x?~", 0, "", 1'b0, '0},
        '{"4,4,1,2,3,4,2,1,0~junk", 0, "", 1'b0, '0},
        '{"4,4,1,2,3,4,2,1,0x", 0, "", 1'b1, ErrorOut},
        '{"5,4,1,2,3,4,2,1,0", 0, "", 1'b1, UnsupOut},
        '{"4,4,256,511,999,0300,2,65535,7", 0, "", 1'b0, '0},
        '{"4,4,1,2,3,4,2,1", 0, "", 1'b1, ErrorOut},
        '{"4,4,1,2,3,4,2,1,0,9", 0, "", 1'b1, ErrorOut},
        '{"4", 512, "9", 1'b1, ErrorOut},
        '{"4,20,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,2,7,8", 0, "",
          1'b0, '0},
        '{"4,4,1,2,3,4,0", 0, "", 1'b0, '0},
        '{"\377", 0, "", 1'b1, ErrorOut},
        '{"6,4,1,2,3,4,2,0,80", 0, "", 1'b0, '0},
        '{",,,", 0, "", 1'b1, ErrorOut},
        '{" \f ", 0, "", 1'b1, ErrorOut},
        '{"4,4,1,2,3,4,2,1,0 ", 0, "", 1'b0, '0},
        '{"4,4,1,2,3,4,2,1,0,", 0, "", 1'b1, ErrorOut}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;
    logic     push      = 1'b0;
    logic     full;
    lap_in_t  in_data   = '0;
    logic     empty;
    logic     pop       = 1'b0;
    lap_out_t out_data;

    // Parser model state, one argument at a time.
    scan_phase_t arg_phase;
    int unsigned arg_field;
    logic [7:0]  arg_value;
    logic [7:0]  arg_family;
    logic [7:0]  arg_addr_len;
    logic [7:0]  arg_port_len;
    logic [7:0]  arg_addr [AddrBytes];
    logic [15:0] arg_port;
    bit          arg_bad;
    bit          v6_enabled = 1'b1;

    lap_out_t    pending_results [$];
    logic [7:0]  arg_chars [$];
    int          failures     = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;

    lprt_address_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("lprt_address_parser verification failed");
            $finish;
        end
    end

    function automatic void clear_argument();
        arg_phase    = SKIPPING;
        arg_field    = 0;
        arg_value    = '0;
        arg_family   = '0;
        arg_addr_len = '0;
        arg_port_len = '0;
        arg_port     = '0;
        arg_bad      = 1'b0;
        foreach (arg_addr[i])
            arg_addr[i] = '0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void close_field();
        if (arg_field == 0)
            arg_family = arg_value;
        if (arg_field == 1)
            arg_addr_len = arg_value;
        if (arg_field >= 2 && arg_field < 2 + AddrBytes)
            arg_addr[arg_field - 2] = arg_value;
        if (arg_field >= 2)
        begin
            // The port fields sit after however many address bytes were announced.
            if (arg_field == 32'(arg_addr_len) + 2)
                arg_port_len = arg_value;
            if (arg_field == 32'(arg_addr_len) + 3)
                arg_port[15:8] = arg_value;
            if (arg_field == 32'(arg_addr_len) + 4)
                arg_port[7:0] = arg_value;
        end
        arg_value = '0;
    endfunction

    function automatic void end_scan();
        if (arg_phase != STOPPED)
        begin
            close_field();
            arg_phase = STOPPED;
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (arg_phase == STOPPED)
            return;
        if (arg_phase == SKIPPING)
        begin
            if (c == CH_NUL)
            begin
                end_scan();
                return;
            end
            if (is_blank(c))
                return;
            arg_phase = SCANNING;
        end
        if (c == CH_NUL || is_blank(c))
            end_scan();
        else if (c >= CH_DIG0 && c <= CH_DIG9)
            arg_value = arg_value * 8'd10 + (c - CH_DIG0);
        else if (c == CH_COMMA)
        begin
            close_field();
            arg_field++;
            if (arg_field >= MaxFields)
                end_scan();
        end
        else
        begin
            arg_bad   = 1'b1;
            arg_phase = STOPPED;
        end
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic last_char);
        lap_out_t res;
        scan_char(c);
        if (!last_char)
            return;
        end_scan();
        res        = '0;
        res.status = ST_ERROR;
        if (!arg_bad && arg_field + 1 == 32'(arg_addr_len) + 32'(arg_port_len) + 3)
        begin
            if (arg_family == FAM_IPV4)
            begin
                res.status          = ST_IPV4;
                res.addr_first_half = {arg_addr[0], arg_addr[1], arg_addr[2], arg_addr[3],
                                       32'h0};
                res.port            = arg_port;
            end
            else if (arg_family == FAM_IPV6 && v6_enabled)
            begin
                res.status = ST_IPV6;
                for (int i = 0; i < 8; i++)
                begin
                    res.addr_first_half[63 - 8 * i -: 8]  = arg_addr[i];
                    res.addr_second_half[63 - 8 * i -: 8] = arg_addr[8 + i];
                end
                res.port = arg_port;
            end
            else
                res.status = ST_UNSUP;
        end
        pending_results.push_back(res);
        clear_argument();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            arg_chars.push_back((s[i] == NulMark) ? CH_NUL : s[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        failures++;
        if (failures <= 10)
            $display("result %0d: %s expected %h got %h", results_seen, what, want, got);
    endtask

    // Mostly well-formed arguments with random content; the rest are broken
    // sequences or plain noise.
    task automatic build_random_argument();
        int kind;
        int family;
        int alen;
        int plen;
        int fields [$];
        arg_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            repeat ($urandom_range(1, 12))
                arg_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            arg_chars.push_back(pick_blank());
        kind   = $urandom_range(0, 99);
        family = (kind < 45) ? 4 : (kind < 90) ? 6 : $urandom_range(0, 255);
        alen   = (family == 6) ? 16 : 4;
        if ($urandom_range(0, 99) < 15)
            alen = $urandom_range(0, 20);
        plen = 2;
        if ($urandom_range(0, 99) < 15)
            plen = $urandom_range(0, 3);
        fields.push_back(family);
        fields.push_back(alen);
        repeat (alen)
            fields.push_back($urandom_range(0, 255));
        fields.push_back(plen);
        repeat (plen)
            fields.push_back($urandom_range(0, 255));
        kind = $urandom_range(0, 99);
        if (kind < 5)
            void'(fields.pop_back());
        else if (kind < 10)
            fields.push_back($urandom_range(0, 255));
        foreach (fields[i])
        begin
            if (i > 0)
                arg_chars.push_back(CH_COMMA);
            if ($urandom_range(0, 19) == 0)
                add_text("0");
            if ($urandom_range(0, 9) == 0)
                fields[i] = $urandom_range(0, 999);
            add_text($sformatf("%0d", fields[i]));
        end
        if ($urandom_range(0, 19) == 0)
            arg_chars[$urandom_range(0, arg_chars.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
        begin
            arg_chars.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : pick_blank());
            repeat ($urandom_range(0, 3))
                arg_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Pushes the characters held in arg_chars, the final one marked last.
    task automatic send_argument(input bit known, input lap_out_t want);
        bit steady;
        bit stalled;
        int gap;
        steady = ($urandom_range(0, 3) == 0);
        foreach (arg_chars[i])
        begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push    <= 1'b1;
            in_data <= '{ch: arg_chars[i], last: (i == arg_chars.size() - 1)};
            // full only moves at a rising edge, so its value at the falling edge
            // is the one seen by the next rising edge.
            do
            begin
                @(negedge clk);
                stalled = full;
                @(posedge clk);
            end
            while (stalled);
            predict_char(arg_chars[i], i == arg_chars.size() - 1);
        end
        if (known)
            pending_results[pending_results.size() - 1] = want;
    endtask

    task automatic write_v6_enable(input logic value);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IdleWait) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        v6_enabled = value;
    endtask

    initial
    begin : stimulus
        int rand_chars;
        rand_chars = 0;
        clear_argument();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_args[r])
        begin
            arg_chars.delete();
            add_text(directed_args[r].text);
            repeat (directed_args[r].commas)
                arg_chars.push_back(CH_COMMA);
            add_text(directed_args[r].tail);
            send_argument(directed_args[r].known, directed_args[r].want);
        end

        // Alternate IPv6 support off and on between random phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_v6_enable(phase % 2 != 0);
            while (rand_chars < 40 * (phase + 1))
            begin
                build_random_argument();
                rand_chars += arg_chars.size();
                send_argument(1'b0, '0);
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (failures == 0)
            $display("lprt_address_parser verification clean");
        else
            $display("lprt_address_parser verification failed");
        $finish;
    end

    initial
    begin : result_drain
        int       stall_left;
        bit       held_off;
        bit       taken;
        lap_out_t want;
        lap_out_t got;
        stall_left = 0;
        held_off   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // Outputs are sampled before the edge that accepts them.
            @(negedge clk);
            taken = pop && !empty;
            got   = out_data;
            @(posedge clk);
            if (taken)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, status", 64'h0,
                                    64'(got.status));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(got.status));
                    if (got.addr_first_half !== want.addr_first_half)
                        report_mismatch("addr_first_half", want.addr_first_half,
                                        got.addr_first_half);
                    if (got.addr_second_half !== want.addr_second_half)
                        report_mismatch("addr_second_half", want.addr_second_half,
                                        got.addr_second_half);
                    if (got.port !== want.port)
                        report_mismatch("port", 64'(want.port), 64'(got.port));
                end
            end
            // One long hold-off lets the result queue fill and push back on input.
            if (!held_off && results_seen >= 5)
            begin
                held_off   = 1'b1;
                stall_left = HoldOff;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

endmodule
